// ===== src/fixed_point_alu_q24_8_macros.svh =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8 assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FPA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define FPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, command codes and helper functions of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACTION_BITS_DEF = 8;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_SUB      = 4'd1;
    localparam logic [3:0] CMD_MUL      = 4'd2;
    localparam logic [3:0] CMD_DIV      = 4'd3;
    localparam logic [3:0] CMD_INC      = 4'd4;
    localparam logic [3:0] CMD_DEC      = 4'd5;
    localparam logic [3:0] CMD_MIN      = 4'd6;
    localparam logic [3:0] CMD_MAX      = 4'd7;
    localparam logic [3:0] CMD_COMPARE  = 4'd8;
    localparam logic [3:0] CMD_FROM_INT = 4'd9;
    localparam logic [3:0] CMD_TO_INT   = 4'd10;

    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               overflowed;
        logic               divided_by_zero;
    } out_t;

    // control travelling along the chain
    typedef struct packed {
        logic valid;
        in_t  item;
    } ctl_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] value;
    } sat_t;

    // magnitude of a signed 32-bit value, 2^31 fits unsigned
    function automatic logic [31:0] mag32(logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    // saturate a 33-bit signed sum to 32 bits
    function automatic sat_t sat33(logic [32:0] s);
        sat_t r;
        r.ovf   = s[32] ^ s[31];
        r.value = r.ovf ? (s[32] ? MIN32 : MAX32) : s[31:0];
        return r;
    endfunction

    // apply sign to a magnitude and saturate
    function automatic sat_t sat_mag(logic neg, logic [63:0] mag);
        sat_t r;
        if (neg) begin
            r.ovf   = mag > 64'h0000_0000_8000_0000;
            r.value = r.ovf ? MIN32 : 32'(-mag[31:0]);
        end else begin
            r.ovf   = mag > 64'h0000_0000_7FFF_FFFF;
            r.value = r.ovf ? MAX32 : mag[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: develops one quotient bit and forwards the beat.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
    parameter int NB = 40
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  fpa_pkg::ctl_t      in_ctl,
    input  logic signed [63:0] in_prod,
    input  logic [NB-1:0]      in_num,
    input  logic [31:0]        in_rem,
    input  logic [NB-1:0]      in_quot,
    input  logic [31:0]        in_den,
    output fpa_pkg::ctl_t      out_ctl,
    output logic signed [63:0] out_prod,
    output logic [NB-1:0]      out_num,
    output logic [31:0]        out_rem,
    output logic [NB-1:0]      out_quot,
    output logic [31:0]        out_den
);

    logic          valid_reg;
    fpa_pkg::in_t  item_reg;
    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic          fits;
    logic [31:0]   rem_next;

    // shift in the next numerator bit and try the subtract
    always_comb begin
        shifted  = {in_rem, in_num[NB-1]};
        diff     = shifted - {1'b0, in_den};
        fits     = shifted >= {1'b0, in_den};
        rem_next = fits ? diff[31:0] : shifted[31:0];
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_ctl.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= in_ctl.item;
            out_prod <= in_prod;
            out_num  <= {in_num[NB-2:0], 1'b0};
            out_rem  <= rem_next;
            out_quot <= {in_quot[NB-2:0], fits};
            out_den  <= in_den;
        end
    end

    assign out_ctl.valid = valid_reg;
    assign out_ctl.item  = item_reg;

endmodule

// ===== src/fpa_result.sv =====
// ----------------------------------------------------------------------------
// fpa_result
// Final stage: rounding, saturation, command select and the output register.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_q24_8_macros.svh"

module fpa_result #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
    parameter int NB            = 32 + FRACTION_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  fpa_pkg::ctl_t      in_ctl,
    input  logic signed [63:0] in_prod,
    input  logic [31:0]        in_rem,
    input  logic [NB-1:0]      in_quot,
    input  logic [31:0]        in_den,
    output logic               m_valid,
    output fpa_pkg::out_t      m_data
);

    localparam logic [63:0] HALF = 64'(1) << (FRACTION_BITS - 1);

    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [63:0]        prod_mag;
    logic [63:0]        mul_mag;
    logic [NB:0]        div_q;
    logic [FRACTION_BITS:0] a_top;
    fpa_pkg::sat_t      res;
    logic               dz;
    fpa_pkg::out_t      out_next;
    logic               valid_reg;
    fpa_pkg::out_t      data_reg;

    // rounding of product and quotient
    always_comb begin
        a        = in_ctl.item.operand_a;
        b        = in_ctl.item.operand_b;
        prod_mag = in_prod[63] ? 64'(-in_prod) : 64'(in_prod);
        mul_mag  = (prod_mag + HALF) >> FRACTION_BITS;
        div_q    = {1'b0, in_quot} + (NB+1)'({in_rem, 1'b0} >= {1'b0, in_den});
        a_top    = a[31:31-FRACTION_BITS];
    end

    // command decode
    always_comb begin
        res = '0;
        dz  = 1'b0;
        unique case (in_ctl.item.command)
            fpa_pkg::CMD_ADD: res = fpa_pkg::sat33({a[31], a} + {b[31], b});
            fpa_pkg::CMD_SUB: res = fpa_pkg::sat33({a[31], a} - {b[31], b});
            fpa_pkg::CMD_MUL: res = fpa_pkg::sat_mag(in_prod[63], mul_mag);
            fpa_pkg::CMD_DIV: begin
                if (b == 32'sd0) begin
                    dz        = 1'b1;
                    res.value = a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                end else begin
                    res = fpa_pkg::sat_mag(a[31] ^ b[31], 64'(div_q));
                end
            end
            fpa_pkg::CMD_INC: res = fpa_pkg::sat33({a[31], a} + 33'd1);
            fpa_pkg::CMD_DEC: res = fpa_pkg::sat33({a[31], a} - 33'd1);
            fpa_pkg::CMD_MIN: res.value = (a > b) ? b : a;
            fpa_pkg::CMD_MAX: res.value = (a < b) ? b : a;
            fpa_pkg::CMD_COMPARE: res.value = '0;
            fpa_pkg::CMD_FROM_INT: begin
                if ((&a_top) || !(|a_top)) begin
                    res.value = 32'(a <<< FRACTION_BITS);
                end else begin
                    res.ovf   = 1'b1;
                    res.value = a[31] ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
                end
            end
            fpa_pkg::CMD_TO_INT: res.value = 32'(a >>> FRACTION_BITS);
            default: res = '0;
        endcase
        out_next.result_value    = res.value;
        out_next.a_less          = a < b;
        out_next.a_equal         = a == b;
        out_next.a_greater       = a > b;
        out_next.overflowed      = res.ovf;
        out_next.divided_by_zero = dz;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= out_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    `FPA_ASSERT_IMPL(a_flags_onehot, aclk, aresetn, m_valid,
        $onehot({m_data.a_less, m_data.a_equal, m_data.a_greater}))
    `FPA_ASSERT_IMPL(a_dz_no_ovf, aclk, aresetn, m_valid && m_data.divided_by_zero,
        !m_data.overflowed)
    `FPA_ASSERT_IMPL(a_dz_saturates, aclk, aresetn, m_valid && m_data.divided_by_zero,
        m_data.result_value == fpa_pkg::MAX32 || m_data.result_value == fpa_pkg::MIN32)

endmodule

// ===== src/fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 fixed-point ALU with a pipelined restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one beat per operation (command, operand_a,
//   operand_b); m_valid/m_ready/m_data return one result beat per operation,
//   in order.
//   From the accepting edge to m_valid a beat passes one input stage holding
//   the 32x32 multiplier, one division cell per quotient bit (32 +
//   FRACTION_BITS cells), and the rounding/saturation output stage.
//   Every command goes through the same pipeline, so a new beat is taken
//   every cycle while the result side keeps up.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; the pipeline still accepts while the
//   output register is empty or being drained in the same cycle.
//   Reset clears every valid bit; no result is presented after reset until a
//   beat has passed through the pipeline.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
    parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fpa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fpa_pkg::out_t m_data
);

    localparam int NB = 32 + FRACTION_BITS;

    logic               adv;
    logic               front_valid_reg;
    fpa_pkg::in_t       front_item_reg;
    logic signed [63:0] prod_reg;
    logic [NB-1:0]      num_reg;
    logic [31:0]        den_reg;

    fpa_pkg::ctl_t      ctl_w  [0:NB];
    logic signed [63:0] prod_w [0:NB];
    logic [NB-1:0]      num_w  [0:NB];
    logic [31:0]        rem_w  [0:NB];
    logic [NB-1:0]      quot_w [0:NB];
    logic [31:0]        den_w  [0:NB];

    // pipeline moves whenever the output slot is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // input stage with the multiplier
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (adv) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            front_item_reg <= s_data;
            prod_reg       <= s_data.operand_a * s_data.operand_b;
            num_reg        <= {fpa_pkg::mag32(s_data.operand_a), {FRACTION_BITS{1'b0}}};
            den_reg        <= fpa_pkg::mag32(s_data.operand_b);
        end
    end

    assign ctl_w[0].valid = front_valid_reg;
    assign ctl_w[0].item  = front_item_reg;
    assign prod_w[0]      = prod_reg;
    assign num_w[0]       = num_reg;
    assign rem_w[0]       = '0;
    assign quot_w[0]      = '0;
    assign den_w[0]       = den_reg;

    // division cells, one quotient bit each
    for (genvar i = 0; i < NB; i++) begin : g_cell
        fpa_div_cell #(
            .NB (NB)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .in_ctl   (ctl_w[i]),
            .in_prod  (prod_w[i]),
            .in_num   (num_w[i]),
            .in_rem   (rem_w[i]),
            .in_quot  (quot_w[i]),
            .in_den   (den_w[i]),
            .out_ctl  (ctl_w[i+1]),
            .out_prod (prod_w[i+1]),
            .out_num  (num_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_quot (quot_w[i+1]),
            .out_den  (den_w[i+1])
        );
    end

    // rounding, saturation and output register
    fpa_result #(
        .FRACTION_BITS (FRACTION_BITS),
        .NB            (NB)
    ) u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (ctl_w[NB]),
        .in_prod (prod_w[NB]),
        .in_rem  (rem_w[NB]),
        .in_quot (quot_w[NB]),
        .in_den  (den_w[NB]),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
